/* hdl/h264fu_pkg.sv */
// Shared types and constants for the H.264 RTP FU-A packetizer.
package h264fu_pkg;

	// Configuration register indexes
	localparam logic REG_MAX_PAYLOAD = 1'b0;
	localparam logic REG_TS_STEP     = 1'b1;

	localparam logic [11:0] MAX_PAYLOAD_RESET = 12'd1400;
	localparam logic [16:0] TS_STEP_RESET     = 17'd3600;

	// NAL header and FU-A byte fields
	localparam logic [7:0] NAL_TYPE_MASK = 8'h1F;
	localparam logic [7:0] NAL_NRI_MASK  = 8'h60;
	localparam logic [7:0] FU_A_TYPE     = 8'd28;
	localparam logic [7:0] FU_START_BIT  = 8'h80;
	localparam logic [7:0] FU_END_BIT    = 8'h40;
	localparam logic [7:0] NAL_TYPE_SPS  = 8'd7;
	localparam logic [7:0] NAL_TYPE_PPS  = 8'd8;

	// Most results per input item
	localparam int unsigned RES_MAX = 3;

	// One result byte with its flags
	typedef struct packed {
		logic [7:0] out_byte;
		logic       packet_first;
		logic       packet_last;
		logic       run_last;
	} res_t;

	// Result set handed from the step logic to the output buffer
	typedef struct packed {
		logic                  valid;
		logic [1:0]            count;
		res_t [RES_MAX-1:0]    ent;
		logic [15:0]           seq;
		logic [31:0]           stamp;
	} load_t;

endpackage

/* hdl/h264fu_out_buf.sv */
// Three-entry result buffer that serializes one input's results onto the output stream.
module h264fu_out_buf
	import h264fu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  load_t       ld,
	output logic        room,
	output logic [1:0]  level,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // out_byte[7:0], seq_number[23:8], time_value[55:24]
	output logic [1:0]  m_tuser,   // packet_first[0], run_last[1]
	output logic        m_tlast
);

	logic [1:0]             cnt_q;
	res_t [RES_MAX-1:0]     ent_q;
	logic [15:0]            seq_q;
	logic [31:0]            stamp_q;
	logic                   pop;

	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (cnt_q != 2'd0);
	assign level    = cnt_q;
	// New set may load once the last held result leaves this cycle
	assign room     = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_tready);

	assign m_tdata  = {stamp_q, seq_q, ent_q[0].out_byte};
	assign m_tuser  = {ent_q[0].run_last, ent_q[0].packet_first};
	assign m_tlast  = ent_q[0].packet_last;

	// Track how many results are held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (ld.valid) begin
			cnt_q <= ld.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Load a new set, or advance the queue by one on each transfer
	always_ff @(posedge clk) begin
		if (ld.valid) begin
			ent_q   <= ld.ent;
			seq_q   <= ld.seq;
			stamp_q <= ld.stamp;
		end else if (pop) begin
			ent_q[0] <= ent_q[1];
			ent_q[1] <= ent_q[2];
		end
	end

endmodule

/* hdl/h264_rtp_fu_a_packetizer_unit.sv */
// H.264 RTP packetizer with FU-A fragmentation: NAL bytes in, RTP payload bytes out.
// A result is presented in the cycle after the input transfer that causes it.
// Throughput: one input per cycle while each gives one result and the output is ready;
// the byte that opens an FU-A fragment gives three results and holds the input until
// the last of them leaves. The three-entry output buffer sets the rate. Reset clears all
// packet state and counters and loads max_payload with 1400 and timestamp_step with 3600.
module h264_rtp_fu_a_packetizer_unit
	import h264fu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_addr,
	input  logic [16:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // nal_byte[7:0], nal_length[23:8]
	input  logic        s_tuser,   // nal_first
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // out_byte[7:0], seq_number[23:8], time_value[55:24]
	output logic [1:0]  m_tuser,   // packet_first[0], run_last[1]
	output logic        m_tlast    // packet_last
);

	logic [11:0] max_payload_q;
	logic [16:0] ts_step_q;
	logic [7:0]  header_q;
	logic [15:0] bytes_left_q;
	logic [11:0] frag_fill_q;
	logic        frag_mode_q;
	logic        first_chunk_q;
	logic [15:0] seq_q;
	logic [31:0] stamp_q;

	logic [7:0]  header_d;
	logic [15:0] bytes_left_d;
	logic [11:0] frag_fill_d;
	logic        frag_mode_d;
	logic        first_chunk_d;
	logic [15:0] seq_d;
	logic [31:0] stamp_d;

	logic [7:0]  nal_byte;
	logic [15:0] nal_length;
	logic        nal_first;
	logic        accept;
	logic        room;
	logic [1:0]  level;
	logic [11:0] maxp;
	logic [12:0] fill1;
	logic        last;
	logic [7:0]  fu_hdr;
	logic [7:0]  hdr_type;
	logic        keep_stamp;
	logic [31:0] stamp_adv;
	logic [1:0]  n;
	load_t       ld;

	assign nal_byte   = s_tdata[7:0];
	assign nal_length = s_tdata[23:8];
	assign nal_first  = s_tuser;
	assign s_tready   = room;
	assign accept     = s_tvalid && s_tready;

	// Zero payload size acts as one
	assign maxp      = (max_payload_q == 12'd0) ? 12'd1 : max_payload_q;
	assign fill1     = {1'b0, frag_fill_q} + 13'd1;
	assign stamp_adv = stamp_q + {15'd0, ts_step_q};

	// Work out the results and next state for one input byte
	always_comb begin
		header_d      = header_q;
		bytes_left_d  = bytes_left_q;
		frag_fill_d   = frag_fill_q;
		frag_mode_d   = frag_mode_q;
		first_chunk_d = first_chunk_q;
		seq_d         = seq_q;
		stamp_d       = stamp_q;
		n             = 2'd0;
		ld            = '0;
		last          = 1'b0;
		fu_hdr        = 8'd0;
		hdr_type      = 8'd0;
		keep_stamp    = 1'b0;

		if (nal_first) begin
			bytes_left_d  = 16'd0;
			frag_mode_d   = 1'b0;
			frag_fill_d   = 12'd0;
			first_chunk_d = 1'b0;
			if (nal_length != 16'd0) begin
				header_d = nal_byte;
				if (nal_length <= {4'd0, maxp}) begin
					// Whole NAL in one packet
					last = (nal_length == 16'd1);
					n = 2'd1;
					ld.ent[0] = '{out_byte: nal_byte, packet_first: 1'b1,
						packet_last: last, run_last: 1'b1};
					if (last) begin
						hdr_type   = nal_byte & NAL_TYPE_MASK;
						keep_stamp = (hdr_type == NAL_TYPE_SPS) || (hdr_type == NAL_TYPE_PPS);
						seq_d      = seq_q + 16'd1;
						if (!keep_stamp) begin
							stamp_d = stamp_adv;
						end
					end else begin
						bytes_left_d = nal_length - 16'd1;
					end
				end else begin
					// Drop the header byte and open fragmentation
					frag_mode_d   = 1'b1;
					first_chunk_d = 1'b1;
					bytes_left_d  = nal_length - 16'd1;
				end
			end
		end else if (bytes_left_q == 16'd0) begin
			// Stray byte: nothing open
			n = 2'd0;
		end else if (!frag_mode_q) begin
			last = (bytes_left_q == 16'd1);
			n = 2'd1;
			ld.ent[0] = '{out_byte: nal_byte, packet_first: 1'b0,
				packet_last: last, run_last: 1'b1};
			bytes_left_d = bytes_left_q - 16'd1;
			if (last) begin
				hdr_type   = header_q & NAL_TYPE_MASK;
				keep_stamp = (hdr_type == NAL_TYPE_SPS) || (hdr_type == NAL_TYPE_PPS);
				seq_d      = seq_q + 16'd1;
				if (!keep_stamp) begin
					stamp_d = stamp_adv;
				end
			end
		end else begin
			last = (fill1 >= {1'b0, maxp}) || (bytes_left_q == 16'd1);
			if (frag_fill_q == 12'd0) begin
				// Prefix the chunk with FU indicator and FU header
				fu_hdr = header_q & NAL_TYPE_MASK;
				if (first_chunk_q) begin
					fu_hdr = fu_hdr | FU_START_BIT;
				end
				if (bytes_left_q <= {4'd0, maxp}) begin
					fu_hdr = fu_hdr | FU_END_BIT;
				end
				n = 2'd3;
				ld.ent[0] = '{out_byte: (header_q & NAL_NRI_MASK) | FU_A_TYPE,
					packet_first: 1'b1, packet_last: 1'b0, run_last: 1'b0};
				ld.ent[1] = '{out_byte: fu_hdr, packet_first: 1'b0,
					packet_last: 1'b0, run_last: 1'b0};
				ld.ent[2] = '{out_byte: nal_byte, packet_first: 1'b0,
					packet_last: last, run_last: 1'b1};
				first_chunk_d = 1'b0;
			end else begin
				n = 2'd1;
				ld.ent[0] = '{out_byte: nal_byte, packet_first: 1'b0,
					packet_last: last, run_last: 1'b1};
			end
			bytes_left_d = bytes_left_q - 16'd1;
			frag_fill_d  = last ? 12'd0 : fill1[11:0];
			if (last) begin
				seq_d = seq_q + 16'd1;
			end
			if (bytes_left_q == 16'd1) begin
				frag_mode_d = 1'b0;
				frag_fill_d = 12'd0;
				stamp_d     = stamp_adv;
			end
		end

		ld.valid = accept && (n != 2'd0);
		ld.count = n;
		ld.seq   = seq_q;
		ld.stamp = stamp_q;
	end

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RESET;
			ts_step_q     <= TS_STEP_RESET;
		end else if (cfg_wr_en) begin
			if (cfg_addr == REG_MAX_PAYLOAD) begin
				max_payload_q <= cfg_data[11:0];
			end else begin
				ts_step_q <= cfg_data;
			end
		end
	end

	// Advance packet state on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q      <= 8'd0;
			bytes_left_q  <= 16'd0;
			frag_fill_q   <= 12'd0;
			frag_mode_q   <= 1'b0;
			first_chunk_q <= 1'b0;
			seq_q         <= 16'd0;
			stamp_q       <= 32'd0;
		end else if (accept) begin
			header_q      <= header_d;
			bytes_left_q  <= bytes_left_d;
			frag_fill_q   <= frag_fill_d;
			frag_mode_q   <= frag_mode_d;
			first_chunk_q <= first_chunk_d;
			seq_q         <= seq_d;
			stamp_q       <= stamp_d;
		end
	end

	h264fu_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld       (ld),
		.room     (room),
		.level    (level),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Input transfer only when the buffer is empty or draining its last result
	a_accept_room: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ((level == 2'd0) || ((level == 2'd1) && m_tvalid && m_tready)))
		else $error("input transfer while results still pending");

	// Fragment fill stays clear outside fragmentation
	a_fill_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!frag_mode_q |-> (frag_fill_q == 12'd0))
		else $error("fragment fill set outside fragmentation");

	// An open fragmented NAL always has bytes left
	a_frag_open: assert property (@(posedge clk) disable iff (!arst_n)
		frag_mode_q |-> (bytes_left_q != 16'd0))
		else $error("fragmentation open with no bytes left");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the H.264 RTP FU-A packetizer unit.
module tb_top;
	import h264fu_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;

	// One NAL byte offered on the input stream
	typedef struct packed {
		logic [15:0] len;
		logic        start;
		logic [7:0]  data;
	} nal_in_t;

	// One RTP payload byte as it should leave the block
	typedef struct packed {
		logic [7:0]  data;
		logic        pkt_first;
		logic        pkt_last;
		logic [15:0] seq;
		logic [31:0] stamp;
		logic        run_end;
	} rtp_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_addr = 1'b0;
	logic [16:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // nal_byte[7:0], nal_length[23:8]
	logic        s_tuser = 1'b0; // nal_first
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;        // out_byte[7:0], seq_number[23:8], time_value[55:24]
	logic [1:0]  m_tuser;        // packet_first[0], run_last[1]
	logic        m_tlast;        // packet_last

	h264_rtp_fu_a_packetizer_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	nal_in_t   feed_q[$];
	rtp_byte_t rtp_expected[$];

	// Packetizer state mirrored for prediction
	logic [11:0] mp_q = MAX_PAYLOAD_RESET;
	logic [16:0] step_q = TS_STEP_RESET;
	logic [7:0]  hdr_q = '0;
	logic [15:0] remain_q = '0;
	logic [11:0] fill_q = '0;
	logic        frag_on = 1'b0;
	logic        start_pend = 1'b0;
	logic [15:0] seq_q = '0;
	logic [31:0] stamp_q = '0;

	bit in_took;
	bit out_took;
	bit calm;
	bit hold_done;
	int hold_left;
	int send_wait;
	int take_wait;
	int fed_total;
	int taken_total;
	int bytes_seen;
	int packets_seen;
	int settings_used;
	int errors;
	int cycle_count;

	function automatic int pause_len();
		return calm ? 0 : $urandom_range(0, 12);
	endfunction

	function automatic rtp_byte_t tag_byte(input logic [7:0] d, input logic pf,
			input logic pl);
		rtp_byte_t r;
		r.data = d;
		r.pkt_first = pf;
		r.pkt_last = pl;
		r.seq = seq_q;
		r.stamp = stamp_q;
		r.run_end = 1'b0;
		return r;
	endfunction

	// Close a NAL sent whole; SPS and PPS keep the timestamp
	task automatic close_single();
		seq_q = seq_q + 16'd1;
		if ((hdr_q & NAL_TYPE_MASK) != NAL_TYPE_SPS && (hdr_q & NAL_TYPE_MASK) != NAL_TYPE_PPS)
			stamp_q = stamp_q + step_q;
	endtask

	// Work out the payload bytes that one NAL byte produces
	task automatic packetize(input logic [7:0] b, input logic start, input logic [15:0] len);
		rtp_byte_t   batch [3];
		int          n;
		logic [11:0] chunk;
		logic [7:0]  fu_hdr;
		logic [12:0] fill_next;
		logic        closes;
		n = 0;
		chunk = (mp_q == 12'd0) ? 12'd1 : mp_q;
		if (start) begin
			remain_q = '0;
			frag_on = 1'b0;
			fill_q = '0;
			start_pend = 1'b0;
			if (len != 16'd0) begin
				hdr_q = b;
				if (len <= chunk) begin
					batch[n] = tag_byte(b, 1'b1, len == 16'd1);
					n++;
					if (len == 16'd1)
						close_single();
					else
						remain_q = len - 16'd1;
				end else begin
					frag_on = 1'b1;
					start_pend = 1'b1;
					remain_q = len - 16'd1;
				end
			end
		end else if (remain_q != 16'd0) begin
			if (!frag_on) begin
				closes = (remain_q == 16'd1);
				batch[n] = tag_byte(b, 1'b0, closes);
				n++;
				remain_q = remain_q - 16'd1;
				if (closes)
					close_single();
			end else begin
				// Open a fragment with FU indicator and FU header
				if (fill_q == 12'd0) begin
					fu_hdr = hdr_q & NAL_TYPE_MASK;
					if (start_pend)
						fu_hdr = fu_hdr | FU_START_BIT;
					if (remain_q <= chunk)
						fu_hdr = fu_hdr | FU_END_BIT;
					batch[n] = tag_byte((hdr_q & NAL_NRI_MASK) | FU_A_TYPE, 1'b1, 1'b0);
					n++;
					batch[n] = tag_byte(fu_hdr, 1'b0, 1'b0);
					n++;
					start_pend = 1'b0;
				end
				fill_next = fill_q + 13'd1;
				closes = (fill_next >= chunk) || (remain_q == 16'd1);
				batch[n] = tag_byte(b, 1'b0, closes);
				n++;
				remain_q = remain_q - 16'd1;
				fill_q = closes ? 12'd0 : fill_next[11:0];
				if (closes)
					seq_q = seq_q + 16'd1;
				if (remain_q == 16'd0) begin
					frag_on = 1'b0;
					fill_q = '0;
					stamp_q = stamp_q + step_q;
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			batch[i].run_end = (i == n - 1);
			rtp_expected.push_back(batch[i]);
		end
	endtask

	// Check outputs, then predict from the input transfer at this edge
	always @(posedge clk) begin : monitor
		rtp_byte_t want;
		if (arst_n) begin
			cycle_count++;
			in_took = s_tvalid && s_tready;
			out_took = m_tvalid && m_tready;
			if (out_took) begin
				bytes_seen++;
				if (m_tlast)
					packets_seen++;
				if (rtp_expected.size() == 0) begin
					$error("unexpected result transfer: out_byte %0h", m_tdata[7:0]);
					errors++;
				end else begin
					want = rtp_expected.pop_front();
					if (m_tdata[7:0] !== want.data) begin
						$error("out_byte: expected %0h, got %0h", want.data, m_tdata[7:0]);
						errors++;
					end
					if (m_tuser[0] !== want.pkt_first) begin
						$error("packet_first: expected %0d, got %0d", want.pkt_first,
							m_tuser[0]);
						errors++;
					end
					if (m_tlast !== want.pkt_last) begin
						$error("packet_last: expected %0d, got %0d", want.pkt_last, m_tlast);
						errors++;
					end
					if (m_tdata[23:8] !== want.seq) begin
						$error("seq_number: expected %0d, got %0d", want.seq, m_tdata[23:8]);
						errors++;
					end
					if (m_tdata[55:24] !== want.stamp) begin
						$error("time_value: expected %0d, got %0d", want.stamp,
							m_tdata[55:24]);
						errors++;
					end
					if (m_tuser[1] !== want.run_end) begin
						$error("run_last: expected %0d, got %0d", want.run_end, m_tuser[1]);
						errors++;
					end
				end
			end
			if (in_took) begin
				taken_total++;
				packetize(s_tdata[7:0], s_tuser, s_tdata[23:8]);
			end
		end
	end

	// Offer queued NAL bytes, with a random gap before each one
	always @(negedge clk) begin : driver
		nal_in_t cur;
		if (arst_n) begin
			if (s_tvalid && !in_took) begin
				// hold the offered byte until it is taken
			end else if (send_wait > 0) begin
				send_wait--;
				s_tvalid <= 1'b0;
			end else if (feed_q.size() > 0) begin
				cur = feed_q.pop_front();
				s_tdata <= {cur.len, cur.data};
				s_tuser <= cur.start;
				s_tvalid <= 1'b1;
				send_wait = pause_len();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Stall the output at random; once hold it off long enough to back up the input
	always @(negedge clk) begin : receiver
		if (arst_n) begin
			if (out_took)
				take_wait = pause_len();
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!hold_done && taken_total > 100 && feed_q.size() > 40) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (take_wait > 0) begin
				take_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic push_byte(input logic [7:0] d, input logic st, input logic [15:0] len);
		nal_in_t it;
		it.data = d;
		it.start = st;
		it.len = len;
		feed_q.push_back(it);
		fed_total++;
	endtask

	// Queue the header byte of a NAL and count-1 payload bytes
	task automatic queue_nal(input logic [7:0] hdr, input logic [15:0] len, input int count);
		push_byte(hdr, 1'b1, len);
		for (int i = 1; i < count; i++)
			push_byte(8'($urandom_range(0, 255)), 1'b0, 16'($urandom_range(0, 65535)));
	endtask

	// Wait until every byte is taken and every result has come, then let the block settle
	task automatic drain();
		do @(negedge clk); while (taken_total != fed_total || rtp_expected.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [16:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		if (idx == REG_MAX_PAYLOAD)
			mp_q = val[11:0];
		else if (idx == REG_TS_STEP)
			step_q = val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_regs(input logic [16:0] mp_val, input logic [16:0] step_val);
		write_reg(REG_MAX_PAYLOAD, mp_val);
		write_reg(REG_TS_STEP, step_val);
		settings_used++;
	endtask

	// Mostly whole NALs, some cut short, some stray bytes and empty starts
	task automatic random_phase(input int target);
		int         added;
		int         pick;
		int         len;
		int         cnt;
		int         cap;
		int         hi;
		logic [7:0] hdr;
		added = 0;
		@(posedge clk);
		cap = (mp_q == 12'd0) ? 1 : int'(mp_q);
		hi = cap * 3 + 2;
		if (hi > 40)
			hi = 40;
		while (added < target) begin
			pick = $urandom_range(0, 99);
			hdr = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 3) == 0)
				hdr = (hdr & ~NAL_TYPE_MASK) |
					(($urandom_range(0, 1) != 0) ? NAL_TYPE_SPS : NAL_TYPE_PPS);
			if (pick < 80) begin
				len = $urandom_range(1, hi);
				queue_nal(hdr, 16'(len), len);
				added += len;
			end else if (pick < 88) begin
				len = $urandom_range(1, 65535);
				cnt = $urandom_range(1, (len < 6) ? len : 6);
				queue_nal(hdr, 16'(len), cnt);
				added += cnt;
			end else if (pick < 94) begin
				push_byte(8'($urandom_range(0, 255)), 1'b0, 16'($urandom_range(0, 65535)));
			end else begin
				push_byte(hdr, 1'b1, 16'd0);
			end
		end
		drain();
	endtask

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		settings_used = 1;

		// Reset settings: stray byte, SPS/PPS, empty start, header extremes, restarts
		@(posedge clk);
		push_byte(8'hA5, 1'b0, 16'h5A5A);
		queue_nal(8'h67, 16'd1, 1);
		queue_nal(8'h68, 16'd2, 2);
		push_byte(8'h41, 1'b1, 16'd0);
		queue_nal(8'h00, 16'd1, 1);
		queue_nal(8'hFF, 16'hFFFF, 2);
		queue_nal(8'h65, 16'd1401, 2);
		drain();

		// Small chunks: lone fragment, exact fit, then a payload size change mid NAL
		set_regs(17'd4, 17'd1);
		@(posedge clk);
		queue_nal(8'h65, 16'd5, 5);
		queue_nal(8'h41, 16'd4, 4);
		queue_nal(8'h5C, 16'd12, 6);
		drain();
		write_reg(REG_MAX_PAYLOAD, 17'd2);
		@(posedge clk);
		for (int i = 0; i < 7; i++)
			push_byte(8'($urandom_range(0, 255)), 1'b0, 16'($urandom_range(0, 65535)));
		drain();

		// Random traffic across a spread of settings, extremes included
		set_regs(17'h1F000, 17'd90000);
		random_phase(57);
		set_regs(17'd1, 17'h1FFFF);
		random_phase(57);
		calm = 1'b1;
		set_regs(17'd2, 17'd0);
		random_phase(57);
		calm = 1'b0;
		set_regs(17'd3, 17'($urandom_range(0, 131071)));
		random_phase(57);
		set_regs(17'd16, 17'd3600);
		random_phase(57);
		set_regs(17'd4095, 17'h1FFFF);
		random_phase(50);
		set_regs(17'd7, 17'd1);
		random_phase(57);
		calm = 1'b1;
		set_regs(17'd1400, 17'd3600);
		random_phase(40);

		$display("Ran %0d NAL byte transfers into %0d payload bytes in %0d RTP packets",
			taken_total, bytes_seen, packets_seen);
		$display("over %0d register settings, with one long output hold-off.", settings_used);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
